>>> rtl/ncpm_pkg.sv
package ncpm_pkg;

	localparam int DIST_W = 34;
	localparam int RSQ_W  = 24;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic [1:0] CFG_ENTRIES = 2'd0;
	localparam logic [1:0] CFG_SEARCH  = 2'd1;
	localparam logic [1:0] CFG_ACCEPT  = 2'd2;

	localparam logic [8:0]        ENTRIES_RST = 9'd0;
	localparam logic [RSQ_W-1:0]  SRCH_SQ_RST = 24'd57600;
	localparam logic [RSQ_W-1:0]  ACC_SQ_RST  = 24'd6400;
	localparam logic [DIST_W-1:0] DIST_NONE   = {DIST_W{1'b1}};

	typedef struct packed {
		logic               cmd;
		logic [7:0]         entry_index;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic               entry_visible;
	} req_t;

	typedef struct packed {
		logic              match_found;
		logic [7:0]        match_index;
		logic [DIST_W-1:0] distance_sq;
		logic              match_accepted;
	} rsp_t;

	typedef struct packed {
		logic               op;
		logic [7:0]         entry_index;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic               entry_visible;
	} job_t;

	typedef struct packed {
		logic [8:0]       entries;
		logic [RSQ_W-1:0] srch_sq;
		logic [RSQ_W-1:0] acc_sq;
	} cfg_t;

	typedef struct packed {
		logic clearing;
	} bk_stat_t;

endpackage

>>> rtl/ncpm_req_if.sv
interface ncpm_req_if;
	logic               valid;
	logic               ready;
	ncpm_pkg::req_t     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

>>> rtl/ncpm_rsp_if.sv
interface ncpm_rsp_if;
	logic               valid;
	logic               ready;
	ncpm_pkg::rsp_t     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

>>> rtl/nearest_catalog_point_match_unit.sv
// channel   dir  payload                                          transfer
// req       in   cmd, entry_index, pos_x, pos_y, entry_visible    valid & ready
// rsp       out  match_found, match_index, distance_sq, accepted  valid & ready
// cfg       in   cfg_idx, cfg_data                                cfg_we
//
// A load passes through the request queue and is written to the catalog when the idle back end takes it.
// With the back end idle, a query taken from req scans min(entries_in_use,
// CATALOG_DEPTH) catalog entries before its result is valid: one catalog
// read per cycle, three distance stages to drain, one result.
// After reset a clearing pass over all CATALOG_DEPTH entries keeps req.ready low.
// A two-request queue lets req be taken while a result waits on rsp.
module nearest_catalog_point_match_unit #(
	parameter int CATALOG_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	ncpm_req_if.sink    req,
	ncpm_rsp_if.source  rsp,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [11:0] cfg_data
);

	ncpm_pkg::cfg_t     cfg_q;
	ncpm_pkg::bk_stat_t stat;
	ncpm_pkg::job_t     job;
	logic               job_valid;
	logic               job_ready;
	logic [ncpm_pkg::RSQ_W-1:0] sq_w;

	assign sq_w = {12'd0, cfg_data} * {12'd0, cfg_data};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.entries <= ncpm_pkg::ENTRIES_RST;
			cfg_q.srch_sq <= ncpm_pkg::SRCH_SQ_RST;
			cfg_q.acc_sq  <= ncpm_pkg::ACC_SQ_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				ncpm_pkg::CFG_ENTRIES: cfg_q.entries <= cfg_data[8:0];
				ncpm_pkg::CFG_SEARCH:  cfg_q.srch_sq <= sq_w;
				ncpm_pkg::CFG_ACCEPT:  cfg_q.acc_sq  <= sq_w;
				default: begin
				end
			endcase
		end
	end

	ncpm_front #(
		.CATALOG_DEPTH(CATALOG_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.stat      (stat),
		.job_valid (job_valid),
		.job_ready (job_ready),
		.job       (job)
	);

	ncpm_back #(
		.CATALOG_DEPTH(CATALOG_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job_ready (job_ready),
		.job       (job),
		.cfg       (cfg_q),
		.stat      (stat),
		.rsp       (rsp)
	);

endmodule

>>> rtl/ncpm_front.sv
module ncpm_front #(
	parameter int CATALOG_DEPTH = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	ncpm_req_if.sink             req,
	input  ncpm_pkg::bk_stat_t   stat,
	output logic                 job_valid,
	input  logic                 job_ready,
	output ncpm_pkg::job_t       job
);

	ncpm_pkg::job_t q_mem [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       take;
	logic       keep;
	logic       push;
	logic       pop;

	assign req.ready = (cnt_q != 2'd2) && !stat.clearing;
	assign take      = req.valid && req.ready;
	// drop loads aimed past the end of the catalog
	assign keep      = (req.data.cmd == ncpm_pkg::CMD_QUERY) ||
	                   (int'(req.data.entry_index) < CATALOG_DEPTH);
	assign push      = take && keep;
	assign job_valid = (cnt_q != 2'd0);
	assign pop       = job_valid && job_ready;
	assign job       = q_mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= '{op:            req.data.cmd,
			                     entry_index:   req.data.entry_index,
			                     pos_x:         req.data.pos_x,
			                     pos_y:         req.data.pos_y,
			                     entry_visible: req.data.entry_visible};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

>>> rtl/ncpm_back.sv
module ncpm_back #(
	parameter int CATALOG_DEPTH = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 job_valid,
	output logic                 job_ready,
	input  ncpm_pkg::job_t       job,
	input  ncpm_pkg::cfg_t       cfg,
	output ncpm_pkg::bk_stat_t   stat,
	ncpm_rsp_if.source           rsp
);

	localparam int AW   = (CATALOG_DEPTH > 1) ? $clog2(CATALOG_DEPTH) : 1;
	localparam int CW   = $clog2(CATALOG_DEPTH + 1);
	localparam int LW   = (CW > 9) ? CW : 9;
	localparam int DW   = ncpm_pkg::DIST_W;

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_SCAN  = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [32:0]   mem [CATALOG_DEPTH];
	logic [1:0]    st_q;
	logic [AW-1:0] clr_q;
	logic [LW-1:0] scan_cnt_q;
	logic [LW-1:0] n_q;
	logic [LW-1:0] ent_ext;
	logic [LW-1:0] n_lim;
	logic [15:0]   qx_q;
	logic [15:0]   qy_q;

	logic          mem_we;
	logic [AW-1:0] mem_wa;
	logic [32:0]   mem_wd;
	logic [AW+7:0] job_addr_ext;
	logic          issue;

	logic [32:0]   rd_s1;
	logic          v_s1;
	logic [AW-1:0] idx_s1;
	logic          v_s2;
	logic [AW-1:0] idx_s2;
	logic [31:0]   dx2_s2;
	logic [31:0]   dy2_s2;
	logic          v_s3;
	logic [AW-1:0] idx_s3;
	logic [DW-1:0] sum_s3;

	logic signed [16:0] dx_w;
	logic signed [16:0] dy_w;
	logic signed [33:0] sqx_w;
	logic signed [33:0] sqy_w;

	logic [DW-1:0] best_q;
	logic [AW-1:0] best_idx_q;
	logic [AW+7:0] best_idx_ext;
	logic          found;
	logic          accepted;
	logic          rsp_free;
	logic          rsp_load;
	logic          rsp_valid_q;
	ncpm_pkg::rsp_t rsp_q;

	assign stat.clearing = (st_q == ST_CLEAR);
	assign job_ready     = (st_q == ST_IDLE);

	assign job_addr_ext = {{AW{1'b0}}, job.entry_index};
	assign mem_we = (st_q == ST_CLEAR) ||
	                (job_ready && job_valid && (job.op == ncpm_pkg::CMD_LOAD));
	assign mem_wa = (st_q == ST_CLEAR) ? clr_q : job_addr_ext[AW-1:0];
	assign mem_wd = (st_q == ST_CLEAR) ? 33'd0 :
	                {job.entry_visible, job.pos_x, job.pos_y};

	assign ent_ext = LW'(cfg.entries);
	assign n_lim   = (ent_ext > LW'(CATALOG_DEPTH)) ? LW'(CATALOG_DEPTH) : ent_ext;
	assign issue   = (st_q == ST_SCAN) && (scan_cnt_q < n_q);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			rd_s1 <= mem[scan_cnt_q[AW-1:0]];
		end
	end

	assign dx_w  = $signed({rd_s1[31], rd_s1[31:16]}) - $signed({qx_q[15], qx_q});
	assign dy_w  = $signed({rd_s1[15], rd_s1[15:0]}) - $signed({qy_q[15], qy_q});
	assign sqx_w = 34'(dx_w) * 34'(dx_w);
	assign sqy_w = 34'(dy_w) * 34'(dy_w);

	always_ff @(posedge clk) begin
		idx_s1 <= scan_cnt_q[AW-1:0];
		idx_s2 <= idx_s1;
		dx2_s2 <= sqx_w[31:0];
		dy2_s2 <= sqy_w[31:0];
		idx_s3 <= idx_s2;
		sum_s3 <= {2'b00, dx2_s2} + {2'b00, dy2_s2};
		if (job_ready && job_valid && (job.op == ncpm_pkg::CMD_QUERY)) begin
			qx_q <= job.pos_x;
			qy_q <= job.pos_y;
			n_q  <= n_lim;
		end
	end

	assign best_idx_ext = {8'd0, best_idx_q};
	assign found        = (best_q <= {10'd0, cfg.srch_sq});
	assign accepted     = found && (best_q < {10'd0, cfg.acc_sq});
	assign rsp_free     = !rsp_valid_q || rsp.ready;
	assign rsp_load     = (st_q == ST_DONE) && rsp_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_CLEAR;
			clr_q       <= '0;
			scan_cnt_q  <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			best_q      <= ncpm_pkg::DIST_NONE;
			best_idx_q  <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1 && rd_s1[32];
			v_s3 <= v_s2;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (st_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(CATALOG_DEPTH - 1)) begin
						st_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (job_valid && (job.op == ncpm_pkg::CMD_QUERY)) begin
						scan_cnt_q <= '0;
						best_q     <= ncpm_pkg::DIST_NONE;
						best_idx_q <= '0;
						st_q       <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (issue) begin
						scan_cnt_q <= scan_cnt_q + LW'(1);
					end
					if (v_s3 && (sum_s3 < best_q)) begin
						best_q     <= sum_s3;
						best_idx_q <= idx_s3;
					end
					if (!issue && !v_s1 && !v_s2 && !v_s3) begin
						st_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (rsp_free) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q.match_found    <= found;
			rsp_q.match_index    <= found ? best_idx_ext[7:0] : 8'd0;
			rsp_q.distance_sq    <= best_q;
			rsp_q.match_accepted <= accepted;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	a_accept_needs_found: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.match_accepted |-> rsp_q.match_found)
		else $error("accepted result without a match");

	a_miss_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && !rsp_q.match_found |-> (rsp_q.match_index == 8'd0))
		else $error("missed result carries a nonzero index");

	a_found_in_radius: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.match_found |->
		(rsp_q.distance_sq <= {10'd0, cfg.srch_sq}))
		else $error("match reported beyond search radius");

	a_drained_at_done: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_DONE) |-> (!v_s1 && !v_s2 && !v_s3))
		else $error("result formed before scan pipeline drained");

endmodule
